FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ipc_pkg.sv
`default_nettype none
package ipc_pkg;

    // Table geometry
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 12;
    localparam int PKT_W   = 32;
    localparam int DIST_W  = 13;
    localparam int INS_W   = 32;

    // Work queue depth
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GIVEN_SLOT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_INSERTIONS = 2'd2;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  src_addr;
        logic [KEY_W-1:0]  dst_addr;
        logic [SLOT_W-1:0] given_slot;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PKT_W-1:0]  packet_count;
        logic              new_key;
        logic              status;
        logic [DIST_W-1:0] distinct_keys;
        logic [INS_W-1:0]  insertions;
    } out_item_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic              lookup;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] slot;
        logic              bad;
        logic              cnt_ins;
    } job_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/ip_address_packet_counter_core.sv
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | in_data   (src_addr, dst_addr, given_slot)
// out      | out_valid/ out_stall | out_data  (slot, count, flags, totals)
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Given-slot items pass through the read and write states to the result register.
// Lookups scan one stored key per cycle.
// After reset a clearing pass zeroes all CAPACITY counters;
// no item is accepted until it ends.
// Input is taken while the two-entry queue has room, even while a result waits.
`default_nettype none
module ip_address_packet_counter_core (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  ipc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output ipc_pkg::out_item_t            out_data,
    input  wire                           cfg_we,
    input  wire [ipc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire                           cfg_data
);

    ipc_pkg::job_t       push_data;
    ipc_pkg::job_t       pop_data;
    ipc_pkg::back_stat_t stat;
    logic                push;
    logic                pop;
    logic                q_empty;
    logic                q_full;

    ipc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .stat      (stat),
        .q_push    (push),
        .q_data    (push_data)
    );

    ipc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    ipc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/ipc_front.sv
`default_nettype none
module ipc_front (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  ipc_pkg::in_item_t                  in_data,
    input  wire                                cfg_we,
    input  wire [ipc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire                                cfg_data,
    input  wire                                q_full,
    input  ipc_pkg::back_stat_t                stat,
    output logic                               q_push,
    output ipc_pkg::job_t                      q_data
);

    logic key_select_reg, key_select_next;
    logic use_given_reg, use_given_next;
    logic cnt_ins_reg, cnt_ins_next;

    // Decode configuration writes
    always_comb
    begin
        key_select_next = key_select_reg;
        use_given_next  = use_given_reg;
        cnt_ins_next    = cnt_ins_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ipc_pkg::CFG_KEY_SELECT:       key_select_next = cfg_data;
                ipc_pkg::CFG_USE_GIVEN_SLOT:   use_given_next  = cfg_data;
                ipc_pkg::CFG_COUNT_INSERTIONS: cnt_ins_next    = cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_select_reg <= 1'b1;
            use_given_reg  <= 1'b1;
            cnt_ins_reg    <= 1'b0;
        end
        else
        begin
            key_select_reg <= key_select_next;
            use_given_reg  <= use_given_next;
            cnt_ins_reg    <= cnt_ins_next;
        end
    end

    // Hold off while the queue is full or the table is being cleared
    assign in_stall = q_full | stat.clearing;
    assign q_push   = in_valid & ~in_stall;

    // Classify the item
    always_comb
    begin
        q_data.lookup  = ~use_given_reg;
        q_data.key     = key_select_reg ? in_data.src_addr : in_data.dst_addr;
        q_data.slot    = in_data.given_slot[ipc_pkg::ADDR_W-1:0];
        q_data.bad     = ({1'b0, in_data.given_slot} >= (ipc_pkg::SLOT_W+1)'(ipc_pkg::CAPACITY));
        q_data.cnt_ins = cnt_ins_reg;
    end

endmodule
`default_nettype wire

FILE: rtl/ipc_queue.sv
`default_nettype none
module ipc_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  ipc_pkg::job_t        push_data,
    input  wire                  pop,
    output ipc_pkg::job_t        pop_data,
    output logic                 empty,
    output logic                 full
);

    ipc_pkg::job_t                  entry_reg [ipc_pkg::QDEPTH];
    logic [ipc_pkg::QPTR_W-1:0]     wptr_reg, wptr_next;
    logic [ipc_pkg::QPTR_W-1:0]     rptr_reg, rptr_next;
    logic [ipc_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == ipc_pkg::QCNT_W'(ipc_pkg::QDEPTH));
    assign pop_data = entry_reg[rptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

FILE: rtl/ipc_back.sv
`default_nettype none
module ipc_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_empty,
    input  ipc_pkg::job_t         q_data,
    output logic                  q_pop,
    output ipc_pkg::back_stat_t   stat,
    output logic                  out_valid,
    input  wire                   out_stall,
    output ipc_pkg::out_item_t    out_data
);

    localparam int AW = ipc_pkg::ADDR_W;
    localparam int CW = ipc_pkg::CNT_W;

    // Key and counter memories
    logic [ipc_pkg::KEY_W-1:0] key_mem [ipc_pkg::CAPACITY];
    logic [ipc_pkg::PKT_W-1:0] cnt_mem [ipc_pkg::CAPACITY];

    ipc_pkg::back_state_t      state_reg, state_next;
    ipc_pkg::job_t             job_reg, job_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             pidx_reg, pidx_next;
    logic                      pvalid_reg, pvalid_next;
    logic [ipc_pkg::KEY_W-1:0] kq_reg;
    logic [ipc_pkg::PKT_W-1:0] cq_reg;
    logic [AW-1:0]             slot_reg, slot_next;
    logic                      newk_reg, newk_next;
    logic [CW-1:0]             distinct_reg, distinct_next;
    logic [ipc_pkg::INS_W-1:0] ins_reg, ins_next;
    logic [AW-1:0]             clr_reg, clr_next;
    ipc_pkg::out_item_t        res_reg, res_next;
    ipc_pkg::out_item_t        out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      key_we;
    logic                      cnt_we;
    logic [AW-1:0]             cnt_waddr;
    logic [ipc_pkg::PKT_W-1:0] cnt_wdata;
    logic [ipc_pkg::PKT_W-1:0] bumped;
    logic                      match;

    assign match  = pvalid_reg && (kq_reg == job_reg.key);
    assign bumped = (&cq_reg) ? cq_reg : cq_reg + 1'b1;

    assign stat.clearing = (state_reg == ipc_pkg::ST_CLEAR);
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

    // Sequence one job: search, insert, read-modify-write, deliver
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        pvalid_next    = 1'b0;
        slot_next      = slot_reg;
        newk_next      = newk_reg;
        distinct_next  = distinct_reg;
        ins_next       = ins_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & out_stall;
        q_pop          = 1'b0;
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = slot_reg;
        cnt_wdata      = bumped;

        case (state_reg)
            ipc_pkg::ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(ipc_pkg::CAPACITY - 1))
                    state_next = ipc_pkg::ST_IDLE;
            end

            ipc_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_data;
                    newk_next = 1'b0;
                    idx_next  = '0;
                    if (q_data.lookup)
                        state_next = ipc_pkg::ST_SEARCH;
                    else if (q_data.bad)
                    begin
                        res_next               = '0;
                        res_next.status        = ipc_pkg::STATUS_FULL;
                        res_next.distinct_keys = ipc_pkg::DIST_W'(distinct_reg);
                        res_next.insertions    = ins_reg;
                        state_next             = ipc_pkg::ST_OUT;
                    end
                    else
                    begin
                        slot_next  = q_data.slot;
                        state_next = ipc_pkg::ST_READ;
                    end
                end
            end

            ipc_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    slot_next  = pidx_reg;
                    state_next = ipc_pkg::ST_READ;
                end
                else if (idx_reg < distinct_reg)
                begin
                    pvalid_next = 1'b1;
                    pidx_next   = idx_reg[AW-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                else if (distinct_reg < CW'(ipc_pkg::CAPACITY))
                begin
                    // Insert the unknown key at the next free slot
                    key_we        = 1'b1;
                    slot_next     = distinct_reg[AW-1:0];
                    distinct_next = distinct_reg + 1'b1;
                    newk_next     = 1'b1;
                    if (job_reg.cnt_ins && !(&ins_reg))
                        ins_next = ins_reg + 1'b1;
                    state_next = ipc_pkg::ST_READ;
                end
                else
                begin
                    res_next               = '0;
                    res_next.status        = ipc_pkg::STATUS_FULL;
                    res_next.distinct_keys = ipc_pkg::DIST_W'(distinct_reg);
                    res_next.insertions    = ins_reg;
                    state_next             = ipc_pkg::ST_OUT;
                end
            end

            ipc_pkg::ST_READ:
            begin
                state_next = ipc_pkg::ST_WRITE;
            end

            ipc_pkg::ST_WRITE:
            begin
                cnt_we                 = 1'b1;
                res_next.slot          = ipc_pkg::SLOT_W'(slot_reg);
                res_next.packet_count  = bumped;
                res_next.new_key       = newk_reg;
                res_next.status        = ipc_pkg::STATUS_OK;
                res_next.distinct_keys = ipc_pkg::DIST_W'(distinct_reg);
                res_next.insertions    = ins_reg;
                state_next             = ipc_pkg::ST_OUT;
            end

            ipc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ipc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ipc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipc_pkg::ST_CLEAR;
            pvalid_reg    <= 1'b0;
            distinct_reg  <= '0;
            ins_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pvalid_reg    <= pvalid_next;
            distinct_reg  <= distinct_next;
            ins_reg       <= ins_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        slot_reg <= slot_next;
        newk_reg <= newk_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Key memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[distinct_reg[AW-1:0]] <= job_reg.key;
        kq_reg <= key_mem[idx_reg[AW-1:0]];
    end

    // Counter memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cq_reg <= cnt_mem[slot_reg];
    end

endmodule
`default_nettype wire

FILE: rtl/ipc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ipc_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 out_valid,
    input wire                 out_stall,
    input ipc_pkg::out_item_t  out_data
);

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // Drop fields of an uncounted item to zero
    `ASSERT_IMPL(a_full_zero, clk, rst_n, out_valid && out_data.status == ipc_pkg::STATUS_FULL, out_data.slot == '0 && out_data.packet_count == '0 && !out_data.new_key)

    // A counted slot never reads back zero
    `ASSERT_IMPL(a_count_nz, clk, rst_n, out_valid && out_data.status == ipc_pkg::STATUS_OK, out_data.packet_count != '0)

    // An insertion leaves at least one stored key
    `ASSERT_IMPL(a_new_key, clk, rst_n, out_valid && out_data.new_key, out_data.status == ipc_pkg::STATUS_OK && out_data.distinct_keys != '0)

endmodule

bind ip_address_packet_counter_core ipc_checker u_ipc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
